>>> sv/gcgr_pkg.sv
`timescale 1ns / 1ps

package gcgr_pkg;

    // access commands
    typedef enum logic [2:0] {
        CMD_HOST_READ  = 3'd0,
        CMD_HOST_WRITE = 3'd1,
        CMD_PORT_WRITE = 3'd2,
        CMD_PORT_READ  = 3'd3,
        CMD_CTRL_WRITE = 3'd4,
        CMD_CTRL_READ  = 3'd5,
        CMD_INT_ACK    = 3'd6,
        CMD_UNUSED     = 3'd7
    } cmd_t;

    // controller port numbers
    localparam logic [2:0] PORT_DATA_LATCH = 3'd0;
    localparam logic [2:0] PORT_CTRL_LATCH = 3'd1;
    localparam logic [2:0] PORT_BUS_CTRL   = 3'd2;
    localparam logic [2:0] PORT_BUS_DIO    = 3'd3;
    localparam logic [2:0] PORT_IN_DATA    = 3'd4;
    localparam logic [2:0] PORT_OUT_DATA   = 3'd5;
    localparam logic [2:0] PORT_MODE       = 3'd6;
    localparam logic [2:0] PORT_SWITCHES   = 3'd7;

    // configuration register indexes
    localparam logic REG_BUS_ADDRESS = 1'b0;
    localparam logic REG_SYS_CTRL    = 1'b1;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int TDATA_W    = 32;

    localparam int IRQ_ENABLE_BIT = 7;

    localparam logic [4:0] BUS_ADDRESS_RST = 5'h15;
    localparam logic [7:0] MODE_RST        = 8'hff;
    localparam logic [7:0] HOST_RD_MARK    = 8'h30;
    localparam logic [7:0] HOST_WR_MODE    = 8'hfd;
    localparam logic [7:0] FORCED_CTRL_RD  = 8'hf7;
    localparam logic [7:0] IFC_ACK_VALUE   = 8'hfd;
    localparam logic [7:0] SWITCH_HIGH     = 8'hc0;
    localparam logic [7:0] ALL_ONES        = 8'hff;

    // bus control line bit positions
    localparam int LN_DAV  = 0;
    localparam int LN_NRFD = 1;
    localparam int LN_NDAC = 2;
    localparam int LN_IFC  = 3;
    localparam int LN_ATN  = 4;
    localparam int LN_SRQ  = 5;
    localparam int LN_REN  = 6;
    localparam int LN_EOI  = 7;

    typedef struct packed {
        logic [7:0] bus_dio_in;
        logic [7:0] bus_ctrl_in;
        logic [7:0] data_byte;
        logic [2:0] port_number;
        logic [1:0] host_offset;
        logic [2:0] cmd;
    } item_t;

    typedef struct packed {
        logic [3:0] pad;
        logic [7:0] bus_ctrl_out;
        logic [7:0] bus_dio_out;
        logic       ctrl_irq;
        logic       host_status;
        logic       host_irq;
        logic       host_flag;
        logic [7:0] read_value;
    } result_t;

endpackage

>>> sv/gpib_card_glue_registers.sv
`timescale 1ns / 1ps

// channel   dir  handshake                     payload
// s_axis    in   s_axis_tvalid/s_axis_tready   one access beat, 32-bit tdata
// m_axis    out  m_axis_tvalid/m_axis_tready   one result beat, 32-bit tdata
// apb       in   psel/penable/pwrite/pready    bus_address @0x0, sys_controller_off @0x4
//
// one beat per cycle sustained while m_axis_tready holds; an access beat is registered in the
// input register and its result in the result register, set by the single decode/update stage
// rst_n clears the glue state to its power-on values and empties both stages
// a stalled result holds in the result register while the input register still
// takes one more beat; s_axis_tready drops only when both stages are full and stalled

module gpib_card_glue_registers
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // cmd[2:0] host_offset[4:3] port_number[7:5] data_byte[15:8]
    // bus_ctrl_in[23:16] bus_dio_in[31:24]
    input  logic [gcgr_pkg::TDATA_W-1:0]     s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // read_value[7:0] host_flag[8] host_irq[9] host_status[10] ctrl_irq[11]
    // bus_dio_out[19:12] bus_ctrl_out[27:20] zero[31:28]
    output logic [gcgr_pkg::TDATA_W-1:0]     m_axis_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [gcgr_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [gcgr_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [gcgr_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);
    import gcgr_pkg::*;

    // configuration
    logic [4:0] bus_address_reg;
    logic       sys_ctrl_off_reg;
    logic       cfg_wr;

    // pipeline
    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_result_reg;
    result_t    result_next;
    logic       advance;

    // glue state
    logic [7:0] control_reg,  control_next;
    logic [7:0] in_data_reg,  in_data_next;
    logic [7:0] out_data_reg, out_data_next;
    logic [7:0] mode_reg,     mode_next;
    logic       force_reg,    force_next;
    logic [7:0] ctrl_latch_reg, ctrl_latch_next;
    logic [7:0] data_latch_reg, data_latch_next;

    // working values for the item in the input register
    cmd_t       cmd;
    logic       ifc_on;
    logic       atn_on;
    logic       clr;
    logic [7:0] rv;
    logic [7:0] co;

    // ---------------- apb port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        case (paddr[2])
            REG_BUS_ADDRESS: prdata = {27'd0, bus_address_reg};
            REG_SYS_CTRL:    prdata = {31'd0, sys_ctrl_off_reg};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_address_reg  <= BUS_ADDRESS_RST;
            sys_ctrl_off_reg <= 1'b0;
        end
        else if (cfg_wr)
        begin
            if (paddr[2] == REG_BUS_ADDRESS)
            begin
                bus_address_reg <= pwdata[4:0];
            end
            else
            begin
                sys_ctrl_off_reg <= pwdata[0];
            end
        end
    end

    // ---------------- flow control ----------------
    // the item in the input register is processed when the result register is free or is being read out
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg <= s_axis_tdata;
        end
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    // ---------------- access decode and state update ----------------
    assign cmd    = cmd_t'(in_item_reg.cmd);
    assign ifc_on = !in_item_reg.bus_ctrl_in[LN_IFC];
    assign atn_on = !in_item_reg.bus_ctrl_in[LN_ATN];

    always_comb
    begin
        rv              = 8'd0;
        control_next    = control_reg;
        in_data_next    = in_data_reg;
        out_data_next   = out_data_reg;
        mode_next       = mode_reg;
        force_next      = force_reg;
        ctrl_latch_next = ctrl_latch_reg;
        data_latch_next = data_latch_reg;

        case (cmd)
            CMD_HOST_READ:
            begin
                rv = out_data_reg;
                if (in_item_reg.host_offset[0])
                begin
                    rv = rv | HOST_RD_MARK;   // offsets 1 and 3
                end
                mode_next  = {4'd0, in_item_reg.host_offset, 2'd0} ^ ALL_ONES;
                force_next = 1'b1;
            end
            CMD_HOST_WRITE:
            begin
                in_data_next = in_item_reg.data_byte;
                mode_next    = {4'd0, in_item_reg.host_offset, 2'd0} ^ HOST_WR_MODE;
                force_next   = 1'b1;
            end
            CMD_PORT_WRITE:
            begin
                case (in_item_reg.port_number)
                    PORT_DATA_LATCH: data_latch_next = in_item_reg.data_byte;
                    PORT_CTRL_LATCH: ctrl_latch_next = in_item_reg.data_byte;
                    PORT_OUT_DATA:   out_data_next   = in_item_reg.data_byte;
                    PORT_MODE:
                    begin
                        mode_next  = MODE_RST;
                        force_next = 1'b0;
                    end
                    default: ;        // read-only ports ignore writes
                endcase
            end
            CMD_PORT_READ:
            begin
                case (in_item_reg.port_number)
                    PORT_BUS_CTRL: rv = ~in_item_reg.bus_ctrl_in;
                    PORT_BUS_DIO:  rv = ~in_item_reg.bus_dio_in;
                    PORT_IN_DATA:  rv = in_data_reg;
                    PORT_MODE:     rv = mode_reg;
                    PORT_SWITCHES: rv = {2'b00, sys_ctrl_off_reg, bus_address_reg} | SWITCH_HIGH;
                    default:       rv = ALL_ONES;  // write-only ports
                endcase
            end
            CMD_CTRL_WRITE: control_next = in_item_reg.data_byte;
            CMD_CTRL_READ:  rv = force_reg ? FORCED_CTRL_RD : ALL_ONES;
            CMD_INT_ACK:    rv = ifc_on ? IFC_ACK_VALUE : ALL_ONES;
            default: ;
        endcase

        // clear condition uses the updated control word
        clr = atn_on && control_next[5];
        if (clr)
        begin
            data_latch_next = 8'd0;
        end

        co = 8'd0;
        if (clr)
        begin
            co[LN_DAV]  = 1'b1;
            co[LN_NRFD] = 1'b1;
            co[LN_NDAC] = 1'b0;
            co[LN_EOI]  = 1'b1;
        end
        else
        begin
            co[LN_DAV]  = control_next[2];
            co[LN_NRFD] = control_next[1];
            co[LN_NDAC] = control_next[6];
            co[LN_EOI]  = !ctrl_latch_next[4];
        end
        co[LN_IFC] = !ctrl_latch_next[3];
        co[LN_ATN] = !ctrl_latch_next[2];
        co[LN_SRQ] = !ctrl_latch_next[0];
        co[LN_REN] = !ctrl_latch_next[1];

        result_next.pad          = 4'd0;
        result_next.read_value   = rv;
        result_next.host_flag    = control_next[3] && !force_next;
        result_next.host_irq     = !control_next[0];
        result_next.host_status  = control_next[4];
        result_next.ctrl_irq     = (ifc_on || clr) && control_next[IRQ_ENABLE_BIT];
        result_next.bus_dio_out  = ~data_latch_next;
        result_next.bus_ctrl_out = co;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            control_reg    <= 8'd0;
            in_data_reg    <= 8'd0;
            out_data_reg   <= 8'd0;
            mode_reg       <= MODE_RST;
            force_reg      <= 1'b0;
            ctrl_latch_reg <= 8'd0;
            data_latch_reg <= 8'd0;
        end
        else if (advance)
        begin
            control_reg    <= control_next;
            in_data_reg    <= in_data_next;
            out_data_reg   <= out_data_next;
            mode_reg       <= mode_next;
            force_reg      <= force_next;
            ctrl_latch_reg <= ctrl_latch_next;
            data_latch_reg <= data_latch_next;
        end
    end

    // ---------------- assertions ----------------
    // input side only stalls when both stages hold a beat and the sink stalls
    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled with room in the pipeline");

    // a new result only appears from a processed access
    a_result_from_stage: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(in_valid_reg))
        else $error("result without an access in the input register");

    // clear condition zeroes the data latch
    a_clear_zeroes_latch: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && clr) |=> (data_latch_reg == 8'd0))
        else $error("data latch not zeroed under clear");

    // host accesses always set the force flag
    a_host_sets_force: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (cmd == CMD_HOST_READ || cmd == CMD_HOST_WRITE)) |=> force_reg)
        else $error("host access did not set force flag");

    // glue state changes only when an access is processed
    a_state_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(advance) && $past(rst_n) |-> $stable(control_reg) && $stable(mode_reg))
        else $error("glue state changed without an access");

endmodule

>>> dv/gpib_card_glue_registers_tb.sv
`timescale 1ns / 1ps

module gpib_card_glue_registers_tb;

    import gcgr_pkg::*;

    logic                   clk;
    logic                   rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // cmd[2:0] host_offset[4:3] port_number[7:5] data_byte[15:8]
    // bus_ctrl_in[23:16] bus_dio_in[31:24]
    logic [TDATA_W-1:0]     s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // read_value[7:0] host_flag[8] host_irq[9] host_status[10] ctrl_irq[11]
    // bus_dio_out[19:12] bus_ctrl_out[27:20] zero[31:28]
    logic [TDATA_W-1:0]     m_axis_tdata;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    gpib_card_glue_registers dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // one row of the directed access list; rv is trusted only when typed is set
    typedef struct {
        cmd_t       op;
        logic [1:0] offs;
        logic [2:0] port;
        logic [7:0] dat;
        logic [7:0] bctl;
        logic [7:0] bdio;
        bit         typed;
        logic [7:0] rv;
    } access_row_t;

    localparam int NUM_ROWS = 26;
    localparam int NUM_PHASES = 5;
    localparam int BEATS_PER_PHASE = 220;

    // bctl 8'hff leaves every bus line released (levels are active low)
    access_row_t access_rows [0:NUM_ROWS-1] = '{
        // power-on values: switches, mode code, control read, output register
        '{CMD_PORT_READ,  2'd0, PORT_SWITCHES,   8'h00, 8'hff, 8'h00, 1'b1, 8'hd5},
        '{CMD_PORT_READ,  2'd0, PORT_MODE,       8'h00, 8'hff, 8'h00, 1'b1, 8'hff},
        '{CMD_CTRL_READ,  2'd0, 3'd0,            8'h00, 8'hff, 8'h00, 1'b1, 8'hff},
        '{CMD_HOST_READ,  2'd0, 3'd0,            8'h00, 8'hff, 8'h00, 1'b1, 8'h00},
        // odd host offsets mark bits 4 and 5, host access sets the force flag
        '{CMD_HOST_READ,  2'd1, 3'd0,            8'h00, 8'hff, 8'h00, 1'b1, 8'h30},
        '{CMD_PORT_READ,  2'd0, PORT_MODE,       8'h00, 8'hff, 8'h00, 1'b1, 8'hfb},
        '{CMD_CTRL_READ,  2'd0, 3'd0,            8'h00, 8'hff, 8'h00, 1'b1, 8'hf7},
        '{CMD_HOST_WRITE, 2'd3, 3'd0,            8'ha5, 8'hff, 8'h00, 1'b1, 8'h00},
        '{CMD_PORT_READ,  2'd0, PORT_MODE,       8'h00, 8'hff, 8'h00, 1'b1, 8'hf1},
        '{CMD_PORT_READ,  2'd0, PORT_IN_DATA,    8'h00, 8'hff, 8'h00, 1'b1, 8'ha5},
        // mode port write restores the mode code and drops the force flag
        '{CMD_PORT_WRITE, 2'd0, PORT_MODE,       8'h00, 8'hff, 8'h00, 1'b1, 8'h00},
        '{CMD_CTRL_READ,  2'd0, 3'd0,            8'h00, 8'hff, 8'h00, 1'b1, 8'hff},
        '{CMD_PORT_WRITE, 2'd0, PORT_OUT_DATA,   8'hff, 8'hff, 8'h00, 1'b1, 8'h00},
        '{CMD_HOST_READ,  2'd3, 3'd0,            8'h00, 8'hff, 8'h00, 1'b1, 8'hff},
        '{CMD_PORT_WRITE, 2'd0, PORT_DATA_LATCH, 8'h81, 8'hff, 8'h00, 1'b0, 8'h00},
        '{CMD_PORT_WRITE, 2'd0, PORT_CTRL_LATCH, 8'h1f, 8'hff, 8'h00, 1'b0, 8'h00},
        '{CMD_CTRL_WRITE, 2'd0, 3'd0,            8'hff, 8'hff, 8'h00, 1'b0, 8'h00},
        // attention asserted with control bit 5 set: bus clear, data latch zeroed
        '{CMD_CTRL_WRITE, 2'd0, 3'd0,            8'hff, 8'hef, 8'h00, 1'b0, 8'h00},
        // interrupt acknowledge while ifc is asserted
        '{CMD_INT_ACK,    2'd0, 3'd0,            8'h00, 8'hf7, 8'h00, 1'b1, 8'hfd},
        '{CMD_PORT_READ,  2'd0, PORT_BUS_CTRL,   8'h00, 8'h5a, 8'h00, 1'b1, 8'ha5},
        '{CMD_PORT_READ,  2'd0, PORT_BUS_DIO,    8'h00, 8'hff, 8'h00, 1'b1, 8'hff},
        // read of a write-only port
        '{CMD_PORT_READ,  2'd0, PORT_DATA_LATCH, 8'h00, 8'hff, 8'h00, 1'b1, 8'hff},
        // write to a read-only port leaves the switches alone
        '{CMD_PORT_WRITE, 2'd0, PORT_SWITCHES,   8'h00, 8'hff, 8'h00, 1'b1, 8'h00},
        '{CMD_PORT_READ,  2'd0, PORT_SWITCHES,   8'h00, 8'hff, 8'h00, 1'b1, 8'hd5},
        // unused command: no state change, zero read value
        '{CMD_UNUSED,     2'd0, 3'd0,            8'hff, 8'h00, 8'hff, 1'b1, 8'h00},
        '{CMD_CTRL_WRITE, 2'd0, 3'd0,            8'h00, 8'h00, 8'hff, 1'b0, 8'h00}
    };

    // predicted glue state, starts at power-on values
    logic [7:0] ctl_word      = 8'h00;
    logic [7:0] host_in_reg   = 8'h00;
    logic [7:0] host_out_reg  = 8'h00;
    logic [7:0] mode_reg      = MODE_RST;
    logic       forced        = 1'b0;
    logic [7:0] bus_ctl_latch = 8'h00;
    logic [7:0] bus_dat_latch = 8'h00;
    logic [4:0] sw_address    = BUS_ADDRESS_RST;
    logic       sw_sys_off    = 1'b0;

    result_t pending_results[$];
    int      mismatch_cnt = 0;
    bit      no_gaps      = 1'b0;

    // apply one access to the predicted state and return the beat it produces
    function automatic result_t glue_access(item_t it);
        result_t    r;
        logic       ifc_on;
        logic       atn_on;
        logic       clr;
        logic [7:0] rv;
        logic [7:0] co;
        logic [7:0] offs_bits;
        r         = '0;
        rv        = 8'h00;
        co        = 8'h00;
        ifc_on    = !it.bus_ctrl_in[LN_IFC];
        atn_on    = !it.bus_ctrl_in[LN_ATN];
        offs_bits = {4'h0, it.host_offset, 2'b00};
        case (it.cmd)
            CMD_HOST_READ:
            begin
                rv = host_out_reg;
                if (it.host_offset[0])
                    rv = rv | HOST_RD_MARK;
                mode_reg = ALL_ONES ^ offs_bits;
                forced   = 1'b1;
            end
            CMD_HOST_WRITE:
            begin
                host_in_reg = it.data_byte;
                mode_reg    = HOST_WR_MODE ^ offs_bits;
                forced      = 1'b1;
            end
            CMD_PORT_WRITE:
            begin
                case (it.port_number)
                    PORT_DATA_LATCH: bus_dat_latch = it.data_byte;
                    PORT_CTRL_LATCH: bus_ctl_latch = it.data_byte;
                    PORT_OUT_DATA:   host_out_reg  = it.data_byte;
                    PORT_MODE:
                    begin
                        mode_reg = ALL_ONES;
                        forced   = 1'b0;
                    end
                    default: ;
                endcase
            end
            CMD_PORT_READ:
            begin
                case (it.port_number)
                    PORT_BUS_CTRL: rv = ~it.bus_ctrl_in;
                    PORT_BUS_DIO:  rv = ~it.bus_dio_in;
                    PORT_IN_DATA:  rv = host_in_reg;
                    PORT_MODE:     rv = mode_reg;
                    PORT_SWITCHES: rv = SWITCH_HIGH | {2'b00, sw_sys_off, sw_address};
                    default:       rv = ALL_ONES;
                endcase
            end
            CMD_CTRL_WRITE: ctl_word = it.data_byte;
            CMD_CTRL_READ:  rv = forced ? FORCED_CTRL_RD : ALL_ONES;
            CMD_INT_ACK:    rv = ifc_on ? IFC_ACK_VALUE : ALL_ONES;
            default: ;
        endcase

        // bus clear: attention asserted while control bit 5 is set
        clr = atn_on && ctl_word[5];
        if (clr)
            bus_dat_latch = 8'h00;

        // handshake lines and eoi are forced during clear, else driven from control word or latch
        co[LN_DAV]  = clr ? 1'b1 : ctl_word[2];
        co[LN_NRFD] = clr ? 1'b1 : ctl_word[1];
        co[LN_NDAC] = clr ? 1'b0 : ctl_word[6];
        co[LN_EOI]  = clr ? 1'b1 : ~bus_ctl_latch[4];
        co[LN_IFC]  = ~bus_ctl_latch[3];
        co[LN_ATN]  = ~bus_ctl_latch[2];
        co[LN_SRQ]  = ~bus_ctl_latch[0];
        co[LN_REN]  = ~bus_ctl_latch[1];

        r.read_value   = rv;
        r.host_flag    = ctl_word[3] & ~forced;
        r.host_irq     = ~ctl_word[0];
        r.host_status  = ctl_word[4];
        r.ctrl_irq     = (ifc_on | clr) & ctl_word[IRQ_ENABLE_BIT];
        r.bus_dio_out  = ~bus_dat_latch;
        r.bus_ctrl_out = co;
        return r;
    endfunction

    // random access: all commands, now and then the unused one
    function automatic item_t random_access();
        item_t it;
        it.cmd         = ($urandom_range(0, 31) == 0) ? CMD_UNUSED : 3'($urandom_range(0, 6));
        it.host_offset = 2'($urandom);
        it.port_number = 3'($urandom);
        it.data_byte   = 8'($urandom);
        it.bus_ctrl_in = 8'($urandom);
        it.bus_dio_in  = 8'($urandom);
        return it;
    endfunction

    task automatic note_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_cnt++;
        if (mismatch_cnt <= 10)
            $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
    endtask

    // compare one result beat against the oldest prediction
    task automatic check_result(result_t got);
        result_t want;
        if (pending_results.size() == 0)
        begin
            note_mismatch("unexpected result beat", 32'(got), 32'd0);
        end
        else
        begin
            want = pending_results.pop_front();
            if (got.read_value !== want.read_value)
                note_mismatch("read_value", 32'(got.read_value), 32'(want.read_value));
            if (got.host_flag !== want.host_flag)
                note_mismatch("host_flag", 32'(got.host_flag), 32'(want.host_flag));
            if (got.host_irq !== want.host_irq)
                note_mismatch("host_irq", 32'(got.host_irq), 32'(want.host_irq));
            if (got.host_status !== want.host_status)
                note_mismatch("host_status", 32'(got.host_status), 32'(want.host_status));
            if (got.ctrl_irq !== want.ctrl_irq)
                note_mismatch("ctrl_irq", 32'(got.ctrl_irq), 32'(want.ctrl_irq));
            if (got.bus_dio_out !== want.bus_dio_out)
                note_mismatch("bus_dio_out", 32'(got.bus_dio_out), 32'(want.bus_dio_out));
            if (got.bus_ctrl_out !== want.bus_ctrl_out)
                note_mismatch("bus_ctrl_out", 32'(got.bus_ctrl_out), 32'(want.bus_ctrl_out));
        end
    endtask

    // offer one access beat, with random gaps ahead of it, and queue its result
    // once the handshake completes
    task automatic send_access(item_t it, result_t want);
        while (!no_gaps && $urandom_range(0, 99) < 18)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= TDATA_W'(it);
        do
            @(posedge clk);
        while (!s_axis_tready);
        pending_results.push_back(want);
    endtask

    // drop valid and hold off until every predicted beat has come back
    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_access(logic wr, logic [APB_ADDR_W-1:0] addr,
                              logic [APB_DATA_W-1:0] wval, output logic [APB_DATA_W-1:0] rval);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wval;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rval = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // read both switch registers back and compare with the predicted settings
    task automatic check_switches();
        logic [APB_DATA_W-1:0] rval;
        apb_access(1'b0, APB_ADDR_W'(REG_BUS_ADDRESS) << 2, '0, rval);
        if (rval !== APB_DATA_W'(sw_address))
            note_mismatch("bus_address readback", rval, APB_DATA_W'(sw_address));
        apb_access(1'b0, APB_ADDR_W'(REG_SYS_CTRL) << 2, '0, rval);
        if (rval !== APB_DATA_W'(sw_sys_off))
            note_mismatch("sys_controller_off readback", rval, APB_DATA_W'(sw_sys_off));
    endtask

    task automatic set_switches(logic [4:0] addr_val, logic sys_off);
        logic [APB_DATA_W-1:0] unused_rd;
        apb_access(1'b1, APB_ADDR_W'(REG_BUS_ADDRESS) << 2, APB_DATA_W'(addr_val), unused_rd);
        apb_access(1'b1, APB_ADDR_W'(REG_SYS_CTRL) << 2, APB_DATA_W'(sys_off), unused_rd);
        sw_address = addr_val;
        sw_sys_off = sys_off;
        check_switches();
    endtask

    // 12 ns clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // result side: random stalls on tready, changed at the falling edge
    always @(negedge clk)
        m_axis_tready <= rst_n && (no_gaps || $urandom_range(0, 99) >= 18);

    // result beats are taken at the rising edge
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            check_result(result_t'(m_axis_tdata));

    // main sequence: reset, directed rows, then random phases at several switch settings
    initial
    begin
        item_t      it;
        result_t    want;
        logic [4:0] phase_addr [0:NUM_PHASES-1];
        logic       phase_sys  [0:NUM_PHASES-1];

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // switch registers must come up at their power-on values
        check_switches();

        // directed rows, typed read values override the prediction
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            it.cmd         = access_rows[i].op;
            it.host_offset = access_rows[i].offs;
            it.port_number = access_rows[i].port;
            it.data_byte   = access_rows[i].dat;
            it.bus_ctrl_in = access_rows[i].bctl;
            it.bus_dio_in  = access_rows[i].bdio;
            want = glue_access(it);
            if (access_rows[i].typed)
                want.read_value = access_rows[i].rv;
            send_access(it, want);
        end
        drain_results();

        // switch settings per phase, extremes first, one random pick
        phase_addr = '{5'd0, 5'd31, 5'($urandom), 5'd31, 5'd0};
        phase_sys  = '{1'b1, 1'b0, 1'($urandom), 1'b1, 1'b0};

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            set_switches(phase_addr[ph], phase_sys[ph]);
            // one phase runs back to back on both sides
            no_gaps = (ph == 2);
            for (int n = 0; n < BEATS_PER_PHASE; n++)
            begin
                it   = random_access();
                want = glue_access(it);
                send_access(it, want);
                // now and then let everything drain mid-phase
                if ($urandom_range(0, 149) == 0)
                    drain_results();
            end
            drain_results();
        end
        no_gaps = 1'b0;

        if (mismatch_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

>>> sim.f
sv/gcgr_pkg.sv
sv/gpib_card_glue_registers.sv
dv/gpib_card_glue_registers_tb.sv
